// File: rtl/core/crlac_pkg.sv
// ----------------------------------------------------------------------------
// crlac_pkg
// Shared types, widths and helpers for the color region labeling core.
// ----------------------------------------------------------------------------
package crlac_pkg;

	localparam int MAX_LABELS = 256;
	localparam int MAX_DIM    = 4096;

	localparam int LABEL_W = $clog2(MAX_LABELS);
	localparam int CNT_W   = LABEL_W + 1;
	localparam int SLOT_W  = LABEL_W + 1;
	localparam int SLOTS   = 2 * MAX_LABELS;
	localparam int COLOR_W = 24;
	localparam int X_W     = $clog2(MAX_DIM);
	localparam int Y_W     = X_W + 1;
	localparam int DIM_W   = 13;
	localparam int AREA_W  = 25;
	localparam int SUM_W   = 36;
	localparam int CENT_W  = 12;
	localparam int ADDR_W  = 3;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_PAST  = 2'd2,
		STAT_BADLB = 2'd3
	} status_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Color memory entry: the color and the hash slot that points at it.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [COLOR_W-1:0] color;
	} color_ent_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [SUM_W-1:0]  sum_x;
		logic [SUM_W-1:0]  sum_y;
	} stats_ent_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return v;
	endfunction

	function automatic logic [SLOT_W-1:0] color_hash(input logic [COLOR_W-1:0] c);
		logic [SLOT_W-1:0] h;
		h = '0;
		for (int i = 0; i < COLOR_W; i++) begin
			h[i % SLOT_W] = h[i % SLOT_W] ^ c[i];
		end
		return h;
	endfunction

endpackage

// File: rtl/core/crlac_if.sv
// ----------------------------------------------------------------------------
// crlac_if
// Valid/ready channels for pixel commands and results.
// ----------------------------------------------------------------------------
interface crlac_in_if;
	import crlac_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;
	logic [LABEL_W-1:0]  label_index;

	modport source (output valid, opcode, red, green, blue, label_index, input ready);
	modport sink (input valid, opcode, red, green, blue, label_index, output ready);
endinterface

interface crlac_out_if;
	import crlac_pkg::*;
	logic                valid;
	logic                ready;
	logic [LABEL_W-1:0]  label;
	logic                new_label;
	logic [1:0]          status;
	logic [COLOR_W-1:0]  region_color;
	logic [AREA_W-1:0]   region_area;
	logic [CENT_W-1:0]   mean_x;
	logic [CENT_W-1:0]   mean_y;
	logic [CNT_W-1:0]    labels_used;

	modport source (output valid, label, new_label, status, region_color, region_area,
		mean_x, mean_y, labels_used, input ready);
	modport sink (input valid, label, new_label, status, region_color, region_area,
		mean_x, mean_y, labels_used, output ready);
endinterface

// File: rtl/core/crlac_ram.sv
// ----------------------------------------------------------------------------
// crlac_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module crlac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/crlac_div.sv
// ----------------------------------------------------------------------------
// crlac_div
// Restoring divider, one quotient bit per cycle, saturating at all ones.
// ----------------------------------------------------------------------------
module crlac_div import crlac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  sum,
	input  logic [AREA_W-1:0] area,
	output logic              done,
	output logic [CENT_W-1:0] quo
);
	localparam int CW = $clog2(CENT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [AREA_W-1:0] rem_q;
	logic [AREA_W-1:0] area_q;
	logic [CENT_W-1:0] low_q;
	logic [CENT_W-1:0] quo_q;
	logic [AREA_W:0]   trial;
	logic [AREA_W:0]   diff;
	logic              ge;
	logic [AREA_W-1:0] high;

	assign high  = AREA_W'(sum[SUM_W-1:CENT_W]);
	assign trial = {rem_q, low_q[CENT_W-1]};
	assign ge    = trial >= {1'b0, area_q};
	assign diff  = trial - {1'b0, area_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
			// A quotient that does not fit saturates without iterating.
			if (area != '0 && high < area) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(CENT_W);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			area_q <= area;
			rem_q  <= high;
			low_q  <= sum[CENT_W-1:0];
			if (area == '0) begin
				quo_q <= '0;
			end else if (high >= area) begin
				quo_q <= '1;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
			low_q <= {low_q[CENT_W-2:0], 1'b0};
			quo_q <= {quo_q[CENT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// File: rtl/core/color_region_label_area_centroid_core.sv
// ----------------------------------------------------------------------------
// color_region_label_area_centroid_core
// Color-keyed region labeling with per-label area and centroid statistics.
// ----------------------------------------------------------------------------
// Commands enter on pix_in and one result per command leaves on res_out, both
// valid/ready; a transfer happens when valid and ready are high at an edge.
// A pixel command takes the next raster position and looks its color up in a
// 512-slot hash map with linear probing. Each probe reads the map memory, then
// the color memory, then checks the entry. A hit adds a statistics
// read-modify-write before the result is registered. A statistics read waits
// for the 12-step centroid dividers, which do not iterate when the mean
// saturates or the area is zero. A past-frame pixel, a bad label, a clear and
// an unused opcode go straight to the result. One command is in flight at a
// time: pix_in.ready is high only while the core is idle, which it is again
// once the result is registered.
// The result sits in an output register until res_out takes it; a stalled
// receiver holds the core in its final state with the next result ready.
// After reset the core marks every map slot empty. A clear needs no such pass:
// a slot is live only when it points at an allocated label that points back.
// The user must change frame_width and frame_height only while idle; the core
// itself does not enforce this.
// ----------------------------------------------------------------------------
module color_region_label_area_centroid_core import crlac_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	crlac_in_if.sink            pix_in,
	crlac_out_if.source         res_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	typedef enum logic [8:0] {
		S_INIT  = 9'b0_0000_0001,
		S_IDLE  = 9'b0_0000_0010,
		S_MAP   = 9'b0_0000_0100,
		S_COLOR = 9'b0_0000_1000,
		S_CHECK = 9'b0_0001_0000,
		S_UPD   = 9'b0_0010_0000,
		S_RD    = 9'b0_0100_0000,
		S_DIV   = 9'b0_1000_0000,
		S_DONE  = 9'b1_0000_0000
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic [CNT_W-1:0]   total_q;
	logic [SLOT_W-1:0]  clr_q;
	logic [COLOR_W-1:0] color_q;
	logic [LABEL_W-1:0] li_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   lab_q;

	logic [LABEL_W-1:0] r_label_q;
	logic               r_new_q;
	logic               r_alloc_q;
	status_t            r_status_q;
	logic [COLOR_W-1:0] r_color_q;
	logic [AREA_W-1:0]  r_area_q;
	logic [CENT_W-1:0]  r_cx_q;
	logic [CENT_W-1:0]  r_cy_q;

	logic               out_valid_q;
	logic [LABEL_W-1:0] o_label_q;
	logic               o_new_q;
	logic [1:0]         o_status_q;
	logic [COLOR_W-1:0] o_color_q;
	logic [AREA_W-1:0]  o_area_q;
	logic [CENT_W-1:0]  o_cx_q;
	logic [CENT_W-1:0]  o_cy_q;
	logic [CNT_W-1:0]   o_used_q;

	logic               map_we;
	logic [SLOT_W-1:0]  map_waddr;
	logic [CNT_W-1:0]   map_wdata;
	logic [CNT_W-1:0]   map_rdata;
	logic               col_we;
	logic [LABEL_W-1:0] col_raddr;
	color_ent_t         col_wdata;
	color_ent_t         col_rdata;
	logic               st_we;
	logic [LABEL_W-1:0] st_waddr;
	logic [LABEL_W-1:0] st_raddr;
	stats_ent_t         st_wdata;
	stats_ent_t         st_rdata;

	logic               div_start;
	logic               dx_done;
	logic               dy_done;
	logic [CENT_W-1:0]  dx_quo;
	logic [CENT_W-1:0]  dy_quo;

	logic               in_xfer;
	logic               out_free;
	logic               live;
	logic               hit;
	logic               wrap;
	logic [SUM_W:0]     sx_add;
	logic [SUM_W:0]     sy_add;
	stats_ent_t         upd;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);
	assign in_xfer  = pix_in.valid && pix_in.ready;
	assign out_free = !out_valid_q || res_out.ready;
	assign pix_in.ready = (state_q == S_IDLE);

	assign live = (lab_q < total_q) && (col_rdata.slot == slot_q);
	assign hit  = live && (col_rdata.color == color_q);
	assign wrap = ({1'b0, x_q} + DIM_W'(1)) >= eff_dim(width_q);

	// Saturating statistics update for a label that already exists.
	assign sx_add = {1'b0, st_rdata.sum_x} + (SUM_W + 1)'(x_q);
	assign sy_add = {1'b0, st_rdata.sum_y} + (SUM_W + 1)'(y_q);
	always_comb begin
		upd.area  = (&st_rdata.area) ? st_rdata.area : st_rdata.area + AREA_W'(1);
		upd.sum_x = sx_add[SUM_W] ? '1 : sx_add[SUM_W-1:0];
		upd.sum_y = sy_add[SUM_W] ? '1 : sy_add[SUM_W-1:0];
	end

	always_comb begin
		map_we    = 1'b0;
		map_waddr = slot_q;
		map_wdata = total_q;
		col_we    = 1'b0;
		st_we     = 1'b0;
		div_start = 1'b0;
		col_raddr = li_q;
		st_raddr  = li_q;
		st_waddr  = total_q[LABEL_W-1:0];
		col_wdata.slot  = slot_q;
		col_wdata.color = color_q;
		st_wdata.area   = AREA_W'(1);
		st_wdata.sum_x  = SUM_W'(x_q);
		st_wdata.sum_y  = SUM_W'(y_q);
		case (state_q)
			// An all-ones slot points past any label, so it never reads as live.
			S_INIT: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '1;
			end
			S_COLOR: col_raddr = map_rdata[LABEL_W-1:0];
			S_CHECK: begin
				st_raddr = lab_q[LABEL_W-1:0];
				if (!live && total_q != CNT_W'(MAX_LABELS)) begin
					map_we = 1'b1;
					col_we = 1'b1;
					st_we  = 1'b1;
				end
			end
			S_UPD: begin
				st_we    = 1'b1;
				st_waddr = lab_q[LABEL_W-1:0];
				st_wdata = upd;
			end
			S_DIV: div_start = !r_new_q;
			default: ;
		endcase
	end

	crlac_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(slot_q), .rdata(map_rdata)
	);

	crlac_ram #(.WIDTH($bits(color_ent_t)), .DEPTH(MAX_LABELS)) u_color (
		.clk(clk), .we(col_we), .waddr(total_q[LABEL_W-1:0]), .wdata(col_wdata),
		.raddr(col_raddr), .rdata(col_rdata)
	);

	crlac_ram #(.WIDTH($bits(stats_ent_t)), .DEPTH(MAX_LABELS)) u_stats (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	crlac_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .sum(st_rdata.sum_x),
		.area(st_rdata.area), .done(dx_done), .quo(dx_quo)
	);

	crlac_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .sum(st_rdata.sum_y),
		.area(st_rdata.area), .done(dy_done), .quo(dy_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_HEIGHT) begin
				height_q <= pwdata[DIM_W-1:0];
			end else begin
				width_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	// r_new_q doubles as the divider launch flag during a statistics read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			r_new_q     <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_out.valid && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						r_new_q <= 1'b0;
						case (pix_in.opcode)
							OP_PIXEL: begin
								if (y_q >= eff_dim(height_q)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_MAP;
								end
							end
							OP_READ: begin
								if (CNT_W'(pix_in.label_index) >= total_q) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_CLEAR: begin
								x_q     <= '0;
								y_q     <= '0;
								total_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MAP:   state_q <= S_COLOR;
				S_COLOR: state_q <= S_CHECK;
				S_CHECK: begin
					if (hit) begin
						state_q <= S_UPD;
					end else if (live) begin
						state_q <= S_MAP;
					end else begin
						if (total_q != CNT_W'(MAX_LABELS)) begin
							total_q <= total_q + CNT_W'(1);
						end
						if (wrap) begin
							x_q <= '0;
							y_q <= y_q + Y_W'(1);
						end else begin
							x_q <= x_q + X_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_UPD: begin
					if (wrap) begin
						x_q <= '0;
						y_q <= y_q + Y_W'(1);
					end else begin
						x_q <= x_q + X_W'(1);
					end
					state_q <= S_DONE;
				end
				S_RD: state_q <= S_DIV;
				S_DIV: begin
					if (r_new_q && dx_done && dy_done) begin
						r_new_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						r_new_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					color_q   <= {pix_in.blue, pix_in.green, pix_in.red};
					li_q      <= pix_in.label_index;
					slot_q    <= color_hash({pix_in.blue, pix_in.green, pix_in.red});
					r_alloc_q <= 1'b0;
					r_color_q <= '0;
					r_area_q  <= '0;
					r_cx_q    <= '0;
					r_cy_q    <= '0;
					if (pix_in.opcode == OP_READ) begin
						r_label_q <= pix_in.label_index;
					end else begin
						r_label_q <= '0;
					end
					if (pix_in.opcode == OP_PIXEL && y_q >= eff_dim(height_q)) begin
						r_status_q <= STAT_PAST;
					end else if (pix_in.opcode == OP_READ &&
							CNT_W'(pix_in.label_index) >= total_q) begin
						r_status_q <= STAT_BADLB;
					end else begin
						r_status_q <= STAT_OK;
					end
				end
			end
			S_COLOR: lab_q <= map_rdata;
			S_CHECK: begin
				if (live && !hit) begin
					slot_q <= slot_q + SLOT_W'(1);
				end else if (!live) begin
					if (total_q == CNT_W'(MAX_LABELS)) begin
						r_status_q <= STAT_FULL;
					end else begin
						r_label_q <= total_q[LABEL_W-1:0];
						r_alloc_q <= 1'b1;
					end
				end else begin
					r_label_q <= lab_q[LABEL_W-1:0];
				end
			end
			S_DIV: begin
				if (!r_new_q) begin
					r_color_q <= col_rdata.color;
					r_area_q  <= st_rdata.area;
				end
				r_cx_q <= dx_quo;
				r_cy_q <= dy_quo;
			end
			S_DONE: begin
				if (out_free) begin
					o_label_q  <= r_label_q;
					o_new_q    <= r_alloc_q;
					o_status_q <= r_status_q;
					o_color_q  <= r_color_q;
					o_area_q   <= r_area_q;
					o_cx_q     <= r_cx_q;
					o_cy_q     <= r_cy_q;
					o_used_q   <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.label        = o_label_q;
	assign res_out.new_label    = o_new_q && out_valid_q;
	assign res_out.status       = o_status_q;
	assign res_out.region_color = o_color_q;
	assign res_out.region_area  = o_area_q;
	assign res_out.mean_x       = o_cx_q;
	assign res_out.mean_y       = o_cy_q;
	assign res_out.labels_used  = o_used_q;
endmodule

// File: rtl/core/crlac_chk.sv
// ----------------------------------------------------------------------------
// crlac_chk
// Port-level checks on the labeling core, attached by bind.
// ----------------------------------------------------------------------------
module crlac_chk import crlac_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_new,
	input logic [1:0]         out_status,
	input logic [LABEL_W-1:0] out_label,
	input logic [CNT_W-1:0]   out_used
);
	// The result register holds while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Only one command is in flight at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while another is in flight");

	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_new |-> out_status == STAT_OK)
		else $error("new label with error status");

	a_past_lbl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == STAT_PAST || out_status == STAT_FULL)
		|-> out_label == '0 && !out_new)
		else $error("rejected pixel carries a label");

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_used <= CNT_W'(MAX_LABELS))
		else $error("label count out of range");
endmodule

bind color_region_label_area_centroid_core crlac_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pix_in.valid), .in_ready(pix_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_new(res_out.new_label), .out_status(res_out.status),
	.out_label(res_out.label), .out_used(res_out.labels_used)
);

// File: bench/tb_channels.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channels
// Bench-side helper types for commands and results of the region labeler.
// ----------------------------------------------------------------------------
package tb_channels;
	import crlac_pkg::*;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [LABEL_W-1:0] label_index;
	} command_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               new_label;
		logic [1:0]         status;
		logic [COLOR_W-1:0] region_color;
		logic [AREA_W-1:0]  region_area;
		logic [CENT_W-1:0]  mean_x;
		logic [CENT_W-1:0]  mean_y;
		logic [CNT_W-1:0]   labels_used;
	} region_result_t;
endpackage

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for color_region_label_area_centroid_core.
// A directed table and a random command stream drive the command channel. A
// labeling model inside the bench predicts each result, and results are
// compared in order with random stalls on both channels. Frame geometry is
// reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module testbench;
	import crlac_pkg::*;
	import tb_channels::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	crlac_in_if  pix_in();
	crlac_out_if res_out();

	color_region_label_area_centroid_core dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .res_out(res_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Labeling model state.
	logic [DIM_W-1:0]   m_width, m_height;
	logic [X_W-1:0]     m_x;
	logic [Y_W-1:0]     m_y;
	logic [CNT_W-1:0]   m_total;
	logic [COLOR_W-1:0] m_color [MAX_LABELS];
	logic [AREA_W-1:0]  m_area  [MAX_LABELS];
	logic [SUM_W-1:0]   m_sx    [MAX_LABELS];
	logic [SUM_W-1:0]   m_sy    [MAX_LABELS];

	region_result_t pending_results[$];
	int  failures;
	int  cycle_count;
	bit  long_stall;
	bit  stim_done;
	int  palette_size;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic logic [CENT_W-1:0] mean_coord(input logic [SUM_W-1:0] s,
			input logic [AREA_W-1:0] a);
		logic [SUM_W-1:0] q;
		if (a == 0) return 0;
		q = s / a;
		return (q > 4095) ? 12'd4095 : q[CENT_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] add_sum(input logic [SUM_W-1:0] s,
			input logic [SUM_W-1:0] v);
		logic [SUM_W:0] t;
		t = s + v;
		return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
	endfunction

	function automatic region_result_t label_command(input command_t c);
		region_result_t r;
		logic [COLOR_W-1:0] col;
		int lab;
		bit found;
		r = '0;
		col = {c.blue, c.green, c.red};
		case (c.opcode)
			OP_PIXEL: begin
				if (m_y >= clamp_dim(m_height)) begin
					r.status = STAT_PAST;
				end else begin
					found = 0;
					lab = 0;
					for (int i = 0; i < m_total; i++) begin
						if (!found && m_color[i] == col) begin
							lab = i;
							found = 1;
						end
					end
					if (!found && m_total >= MAX_LABELS) begin
						r.status = STAT_FULL;
					end else begin
						if (!found) begin
							lab = m_total;
							m_color[lab] = col;
							m_area[lab] = 0;
							m_sx[lab] = 0;
							m_sy[lab] = 0;
							m_total++;
							r.new_label = 1'b1;
						end
						if (m_area[lab] != {AREA_W{1'b1}}) m_area[lab]++;
						m_sx[lab] = add_sum(m_sx[lab], m_x);
						m_sy[lab] = add_sum(m_sy[lab], m_y);
						r.label = LABEL_W'(lab);
					end
					if (m_x + 1 >= clamp_dim(m_width)) begin
						m_x = 0;
						m_y = m_y + 1;
					end else begin
						m_x = m_x + 1;
					end
				end
			end
			OP_READ: begin
				r.label = c.label_index;
				if (c.label_index >= m_total) begin
					r.status = STAT_BADLB;
				end else begin
					r.region_color = m_color[c.label_index];
					r.region_area = m_area[c.label_index];
					r.mean_x = mean_coord(m_sx[c.label_index], m_area[c.label_index]);
					r.mean_y = mean_coord(m_sy[c.label_index], m_area[c.label_index]);
				end
			end
			OP_CLEAR: begin
				m_x = 0;
				m_y = 0;
				m_total = 0;
			end
			default: ;
		endcase
		r.labels_used = m_total;
		return r;
	endfunction

	// Valid stays high from one command to the next when no gap is drawn.
	task automatic send_command(input command_t c, input bit use_expected,
			input region_result_t fixed);
		region_result_t r;
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.opcode <= c.opcode;
		pix_in.red <= c.red;
		pix_in.green <= c.green;
		pix_in.blue <= c.blue;
		pix_in.label_index <= c.label_index;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		r = label_command(c);
		pending_results = {pending_results, use_expected ? fixed : r};
	endtask

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == 0) m_width = v[DIM_W-1:0];
		else m_height = v[DIM_W-1:0];
	endtask

	task automatic drain_results();
		pix_in.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_frame(input logic [12:0] w, input logic [12:0] h);
		drain_results();
		write_register(ADDR_W'(4 * REG_WIDTH), 32'(w));
		write_register(ADDR_W'(4 * REG_HEIGHT), 32'(h));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic command_t random_pixel();
		command_t c;
		int k;
		c = '0;
		c.opcode = OP_PIXEL;
		k = $urandom_range(0, palette_size - 1);
		if ($urandom_range(0, 9) == 0) begin
			{c.blue, c.green, c.red} = 24'($urandom);
		end else begin
			c.red = 8'(k * 37);
			c.green = 8'(k ^ 8'h5a);
			c.blue = k[7:0] + 8'h81;
		end
		return c;
	endfunction

	task automatic check_result();
		region_result_t e;
		if (pending_results.size() == 0) begin
			$error("unexpected result transfer");
			failures++;
			return;
		end
		e = pending_results.pop_front();
		if (res_out.label !== e.label) begin
			$error("label expected %0d actual %0d", e.label, res_out.label); failures++;
		end
		if (res_out.new_label !== e.new_label) begin
			$error("new_label expected %0d actual %0d", e.new_label, res_out.new_label);
			failures++;
		end
		if (res_out.status !== e.status) begin
			$error("status expected %0d actual %0d", e.status, res_out.status); failures++;
		end
		if (res_out.region_color !== e.region_color) begin
			$error("region_color expected %h actual %h", e.region_color, res_out.region_color);
			failures++;
		end
		if (res_out.region_area !== e.region_area) begin
			$error("region_area expected %0d actual %0d", e.region_area, res_out.region_area);
			failures++;
		end
		if (res_out.mean_x !== e.mean_x) begin
			$error("mean_x expected %0d actual %0d", e.mean_x, res_out.mean_x);
			failures++;
		end
		if (res_out.mean_y !== e.mean_y) begin
			$error("mean_y expected %0d actual %0d", e.mean_y, res_out.mean_y);
			failures++;
		end
		if (res_out.labels_used !== e.labels_used) begin
			$error("labels_used expected %0d actual %0d", e.labels_used, res_out.labels_used);
			failures++;
		end
	endtask

	// Result side: random stalls, one long hold-off, in-order comparison.
	initial begin
		int stall;
		res_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall) begin
				res_out.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_stall = 0;
			end
			stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18);
			if (cycle_count % 4000 < 1500) stall = 0;
			if (stall != 0) begin
				res_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_out.ready <= 1'b1;
			@(posedge clk);
			while (!res_out.valid) @(posedge clk);
			check_result();
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Directed table: a typed-in result where obvious, else the model decides.
	typedef struct {
		command_t       cmd;
		bit             typed;
		region_result_t res;
	} table_row_t;

	initial begin
		table_row_t rows[$];
		table_row_t row;
		command_t c;
		failures = 0;
		long_stall = 0;
		stim_done = 0;
		palette_size = 8;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		pix_in.valid = 1'b0; pix_in.opcode = '0; pix_in.red = '0;
		pix_in.green = '0; pix_in.blue = '0; pix_in.label_index = '0;
		m_width = DIM_RESET; m_height = DIM_RESET;
		m_x = 0; m_y = 0; m_total = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Read of label 0 after reset is a bad label.
		row.cmd = '{OP_READ, 0, 0, 0, 0}; row.typed = 1;
		row.res = '{0, 0, STAT_BADLB, 0, 0, 0, 0, 0}; rows = {rows, row};
		row.cmd = '{OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff}; row.typed = 1;
		row.res = '{0, 1, STAT_OK, 0, 0, 0, 0, 1}; rows = {rows, row};
		row.cmd = '{OP_PIXEL, 0, 0, 0, 0}; row.typed = 1;
		row.res = '{1, 1, STAT_OK, 0, 0, 0, 0, 2}; rows = {rows, row};
		row.typed = 0;
		row.cmd = '{OP_PIXEL, 8'hff, 8'hff, 8'hff, 0}; rows = {rows, row};
		row.cmd = '{OP_READ, 0, 0, 0, 0}; rows = {rows, row};
		row.cmd = '{OP_READ, 0, 0, 0, 1}; rows = {rows, row};
		row.cmd = '{OP_READ, 8'hff, 8'hff, 8'hff, 8'hff}; row.typed = 1;
		row.res = '{8'hff, 0, STAT_BADLB, 0, 0, 0, 0, 2}; rows = {rows, row};
		row.cmd = '{2'd3, 8'h12, 8'h34, 8'h56, 8'h78};
		row.res = '{0, 0, STAT_OK, 0, 0, 0, 0, 2}; rows = {rows, row};
		row.cmd = '{OP_CLEAR, 0, 0, 0, 0};
		row.res = '{0, 0, STAT_OK, 0, 0, 0, 0, 0}; rows = {rows, row};
		foreach (rows[i]) send_command(rows[i].cmd, rows[i].typed, rows[i].res);

		// Smallest frame: one pixel, then every further pixel is past the frame.
		set_frame(13'd0, 13'd0);
		for (int i = 0; i < 4; i++) begin
			c = '{OP_PIXEL, i, 1, 2, 0}; send_command(c, 0, '0);
		end
		c = '{OP_READ, 0, 0, 0, 0}; send_command(c, 0, '0);
		c = '{OP_CLEAR, 0, 0, 0, 0}; send_command(c, 0, '0);

		// Oversize frame values clamp; fill the whole table, then overflow it.
		set_frame(13'h1fff, 13'h1fff);
		for (int i = 0; i < MAX_LABELS + 6; i++) begin
			c = '{OP_PIXEL, i[7:0], i[15:8] ^ 8'h3c, 8'h77, 0}; send_command(c, 0, '0);
		end
		for (int i = 0; i < 6; i++) begin
			c = '{OP_READ, 0, 0, 0, $urandom}; send_command(c, 0, '0);
		end
		// The receiver holds off while commands keep coming.
		long_stall = 1;
		for (int i = 0; i < 8; i++) begin
			c = '{OP_PIXEL, 0, 8'h3c, 8'h77, 0}; send_command(c, 0, '0);
		end

		// Random phases over several frame geometries, including one that starts without a clear.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_frame(13'd4096, 13'd4096);
				1: set_frame(13'd7, 13'd5);
				2: set_frame(13'd1, 13'd40);
				3: set_frame(13'd3, 13'd9);
				4: set_frame(13'd33, 13'd2);
				default: set_frame(13'd16, 13'd4096);
			endcase
			if (ph != 3) begin
				c = '{OP_CLEAR, 0, 0, 0, 0}; send_command(c, 0, '0);
			end
			palette_size = (ph == 0) ? 200 : $urandom_range(2, 30);
			for (int i = 0; i < 80; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: c = '{OP_READ, $urandom, $urandom, $urandom,
						$urandom_range(0, palette_size + 3)};
					3: c = '{OP_CLEAR, $urandom, $urandom, $urandom, $urandom};
					4: c = '{2'd3, $urandom, $urandom, $urandom, $urandom};
					default: c = random_pixel();
				endcase
				if (c.opcode == OP_CLEAR && $urandom_range(0, 3) != 0) c = random_pixel();
				send_command(c, 0, '0);
			end
		end

		drain_results();
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/core/crlac_pkg.sv
rtl/core/crlac_if.sv
rtl/core/crlac_ram.sv
rtl/core/crlac_div.sv
rtl/core/color_region_label_area_centroid_core.sv
rtl/core/crlac_chk.sv
bench/tb_channels.sv
bench/testbench.sv
